// ----- sv/rfr_pkg.sv -----
// Package for the preamble-framed receiver with CRC-5 check.
// Holds frame constants, the result status codes, the result struct and the CRC function.
// Depends on nothing; rfr_frame_core and result_frame_receiver_crc5 import it.
`timescale 1ns / 1ps

package rfr_pkg;

    localparam logic [7:0] PRE_FIRST  = 8'hAA;
    localparam logic [7:0] PRE_SECOND = 8'h55;
    localparam logic [4:0] CRC_INIT   = 5'h1F;
    localparam logic [4:0] CRC_POLY   = 5'h05;

    // Byte positions within a frame of eleven bytes.
    localparam logic [3:0] POS_HUNT   = 4'd0;
    localparam logic [3:0] POS_SECOND = 4'd1;
    localparam logic [3:0] POS_FIRST_DATA = 4'd2;
    localparam logic [3:0] POS_LAST   = 4'd10;
    localparam logic [3:0] FRAME_LEN  = 4'd11;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD_PRE = 2'd2,
        ST_BAD_CRC = 2'd3
    } rfr_status_t;

    typedef struct packed {
        rfr_status_t status;
        logic [63:0] payload;
        logic [7:0]  crc_byte;
        logic [31:0] bad_preamble_count;
        logic [31:0] bad_crc_count;
    } rfr_result_t;

    // CRC-5, polynomial x^5+x^2+1, one byte taken MSB first.
    function automatic logic [4:0] rfr_crc5(input logic [4:0] crc_in, input logic [7:0] data);
        logic [4:0] crc;
        logic       fb;
        crc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = crc[4] ^ data[k];
            crc = {crc[3:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// ----- sv/rfr_in_if.sv -----
// Input channel of the framed receiver: valid, ready and one received byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface rfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- sv/rfr_out_if.sv -----
// Result channel of the framed receiver: valid, ready and the result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface rfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] payload;
    logic [7:0]  crc_byte;
    logic [31:0] bad_preamble_count;
    logic [31:0] bad_crc_count;

    modport source (output valid, output status, output payload, output crc_byte,
                    output bad_preamble_count, output bad_crc_count, input ready);
    modport sink   (input valid, input status, input payload, input crc_byte,
                    input bad_preamble_count, input bad_crc_count, output ready);
endinterface

// ----- sv/rfr_frame_core.sv -----
// Frame state of the receiver: byte position, payload shift, running CRC, error counters.
// Computes the result of one byte and advances the state when step is high. Uses rfr_pkg.
`timescale 1ns / 1ps

module rfr_frame_core
    import rfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output rfr_result_t result
);

    logic [3:0]  pos_reg,   pos_next;
    logic [63:0] shift_reg, shift_next;
    logic [4:0]  crc_reg,   crc_next;
    logic [31:0] perr_reg,  perr_next;
    logic [31:0] cerr_reg,  cerr_next;

    logic [3:0]  pos_cur;
    logic [4:0]  crc_calc;
    rfr_status_t status;

    assign crc_calc = rfr_crc5(crc_reg, rx_byte);

    always_comb
    begin
        // Positions past the end of a frame behave like hunting.
        pos_cur    = (pos_reg >= FRAME_LEN) ? POS_HUNT : pos_reg;
        pos_next   = pos_cur;
        shift_next = shift_reg;
        crc_next   = crc_reg;
        perr_next  = perr_reg;
        cerr_next  = cerr_reg;
        status     = ST_NONE;
        priority if (pos_cur == POS_HUNT)
        begin
            if (rx_byte == PRE_FIRST)
            begin
                pos_next = POS_SECOND;
            end
        end
        else if (pos_cur == POS_SECOND)
        begin
            if (rx_byte == PRE_SECOND)
            begin
                pos_next   = POS_FIRST_DATA;
                shift_next = '0;
                crc_next   = CRC_INIT;
            end
            else
            begin
                perr_next = perr_reg + 32'd1;
                status    = ST_BAD_PRE;
                pos_next  = (rx_byte == PRE_FIRST) ? POS_SECOND : POS_HUNT;
            end
        end
        else
        begin
            crc_next = crc_calc;
            if (pos_cur != POS_LAST)
            begin
                shift_next = {shift_reg[55:0], rx_byte};
                pos_next   = pos_cur + 4'd1;
            end
            else
            begin
                pos_next = POS_HUNT;
                if (crc_calc == 5'd0)
                begin
                    status = ST_GOOD;
                end
                else
                begin
                    cerr_next = cerr_reg + 32'd1;
                    status    = ST_BAD_CRC;
                end
            end
        end
    end

    always_comb
    begin
        result.status             = status;
        result.payload            = (status == ST_GOOD) ? shift_reg : 64'd0;
        result.crc_byte           = (status == ST_GOOD) ? rx_byte : 8'd0;
        result.bad_preamble_count = perr_next;
        result.bad_crc_count      = cerr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_HUNT;
            shift_reg <= '0;
            crc_reg   <= CRC_INIT;
            perr_reg  <= '0;
            cerr_reg  <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            crc_reg   <= crc_next;
            perr_reg  <= perr_next;
            cerr_reg  <= cerr_next;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < FRAME_LEN)
        else $error("byte position left the frame range");

    a_bad_pre_count: assert property (@(posedge clk) disable iff (!rst_n)
        step && status == ST_BAD_PRE |=> perr_reg == $past(perr_reg) + 32'd1)
        else $error("bad preamble did not advance its counter");

    a_bad_crc_count: assert property (@(posedge clk) disable iff (!rst_n)
        step && status == ST_BAD_CRC |=> cerr_reg == $past(cerr_reg) + 32'd1)
        else $error("bad crc did not advance its counter");

    a_good_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && status == ST_GOOD |=> pos_reg == POS_HUNT && $stable(cerr_reg))
        else $error("good frame did not restart hunting");

endmodule

// ----- sv/result_frame_receiver_crc5.sv -----
// Top level of the preamble-framed receiver with CRC-5 residual check.
// Holds the input register and the result register around rfr_frame_core.
// Depends on rfr_pkg, rfr_in_if, rfr_out_if and rfr_frame_core.
//
//   Channel  Role    Payload
//   -------  ------  --------------------------------------------------------
//   rx       sink    rx_byte (8 bits)
//   res      source  status, payload, crc_byte, bad_preamble_count, bad_crc_count
//
// Every accepted byte yields exactly one result transfer; it passes the input register, then the result register.
// One byte is accepted in every cycle while res does not stall; the rate is set by the single input register
// feeding the combinational CRC and frame update into the result register.
// rst_n is asynchronous and active low; it restarts preamble hunting, loads the CRC
// with all ones and clears both error counters.
// When res stalls, the held result stays put and one further byte may wait in the
// input register; rx.ready drops only when both registers are full.
`timescale 1ns / 1ps

module result_frame_receiver_crc5
    import rfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rfr_in_if.sink   rx,
    rfr_out_if.source res
);

    // Input register: one received byte waiting for the frame logic.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Result register: the result of the last processed byte.
    logic        out_valid_reg;
    rfr_result_t out_data_reg;

    rfr_result_t step_result;
    logic        out_free;
    logic        step;
    logic        rx_take;

    // The result register can take a new value when it is empty or being drained.
    assign out_free = !out_valid_reg || res.ready;
    // A byte in the input register is processed exactly when its result can be stored,
    // so the frame state advances once per byte and never ahead of the result.
    assign step     = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || out_free;
    assign rx_take  = rx.valid && rx.ready;

    rfr_frame_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (step)
        begin
            out_data_reg <= step_result;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.status             = out_data_reg.status;
    assign res.payload            = out_data_reg.payload;
    assign res.crc_byte           = out_data_reg.crc_byte;
    assign res.bad_preamble_count = out_data_reg.bad_preamble_count;
    assign res.bad_crc_count      = out_data_reg.bad_crc_count;

endmodule
